@@ src/gmw_pkg.sv @@
// Shared types, constants and tables for the geometric mean window filter.
// Depends on nothing; every other file imports it.
package gmw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_HALF   = 4;
    localparam int CHANNELS   = 3;
    localparam int WIN        = 2 * MAX_HALF + 1;
    localparam int RING       = 2 * MAX_HALF;
    localparam int RING_W     = $clog2(RING);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int SEL_W      = $clog2(WIN);
    localparam int PIX_W      = 8 * CHANNELS;
    localparam int LOG_W      = 19;
    localparam int SUM_W      = LOG_W + $clog2(WIN * WIN);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam logic [7:0] FILL = 8'd255;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_X       = 3'd0,
        REG_HALF_Y       = 3'd1,
        REG_FRAME_WIDTH  = 3'd2,
        REG_FRAME_HEIGHT = 3'd3,
        REG_AREA_RECIP   = 3'd4
    } t_reg_idx;

    typedef logic [CHANNELS-1:0][SUM_W-1:0] t_acc;

    // control word broadcast to every window cell
    typedef struct packed {
        logic             clear;
        logic             shift;
        logic             acc_clr;
        logic             acc_add;
        logic             drain;
        logic [SEL_W-1:0] sel;
    } t_cell_ctl;

    typedef logic [LOG_W-1:0] t_log_tab [256];

    // Q3.16 log2 of a sample, zero counted as one, squaring with truncation
    function automatic t_log_tab build_log_tab();
        t_log_tab          tab;
        int unsigned       v;
        int unsigned       n;
        longint unsigned   m;
        logic [LOG_W-1:0]  res;
        for (int s = 0; s < 256; s++) begin
            v = (s == 0) ? 1 : s;
            n = 0;
            for (int j = 1; j < 8; j++) begin
                if ((v >> j) != 0) n = j;
            end
            m = longint'(v) << (16 - n);
            res = LOG_W'(n << 16);
            for (int b = 15; b >= 0; b--) begin
                m = (m * m) >> 16;
                if (m >= 64'd131072) begin
                    m = m >> 1;
                    res[b] = 1'b1;
                end
            end
            tab[s] = res;
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();

    // round(2^(i/16) * 65536)
    localparam logic [17:0] EXP_TAB [17] = '{
        18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
        18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
        18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
    };

endpackage

@@ src/gmw_if.sv @@
// Channel interfaces of the geometric mean window filter: pixel in, pixel out,
// configuration write. Depends on gmw_pkg.
interface gmw_in_if import gmw_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       is_pad;
    modport source (output valid, in_red, in_green, in_blue, is_pad, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, is_pad, output ready);
endinterface

interface gmw_out_if import gmw_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
    modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

interface gmw_cfg_if import gmw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/gmw_line_bank.sv @@
// One row of the line store: MAX_WIDTH packed pixels, read-before-write port.
// Depends on gmw_pkg.
module gmw_line_bank import gmw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [COL_W-1:0] i_addr,
    input  logic [PIX_W-1:0] i_wdata,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rdata;

    // read old word, then store the new one
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/gmw_cell.sv @@
// One window row cell: WIN pixel taps plus per-channel log accumulators that
// drain toward the next cell. Depends on gmw_pkg.
module gmw_cell import gmw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_row_on,
    input  logic [PIX_W-1:0] i_feed,
    input  t_acc             i_acc,
    output t_acc             o_acc
);

    logic [PIX_W-1:0] r_pix [WIN];
    t_acc             r_acc;
    logic [PIX_W-1:0] pix_sel;

    assign pix_sel = r_pix[i_ctl.sel];

    // shift the row of taps, clear on reset or restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int b = 0; b < WIN; b++) r_pix[b] <= '0;
        end else if (i_ctl.shift) begin
            r_pix[0] <= i_feed;
            for (int b = 1; b < WIN; b++) r_pix[b] <= r_pix[b-1];
        end
    end

    // accumulate logs of the selected tap, or hand the sums to the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_add && i_row_on) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_acc[k] <= r_acc[k] + SUM_W'(LOG_TAB[pix_sel[8*k +: 8]]);
            end
        end else if (i_ctl.drain) begin
            r_acc <= i_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ src/geometric_mean_window_filter.sv @@
// Geometric mean window filter, top level: counters, line store, cell chain
// and the exp2 back end. Depends on gmw_pkg, gmw_if, gmw_line_bank, gmw_cell.
//
// Usage: pixels enter in raster order on i_px, one word per handshake; is_pad
// marks flush words that the source appends after each frame (half_y rows
// plus half_x pixels). Results leave on o_px; frame_last marks the final
// pixel of a frame. Configuration words on i_cfg are always taken and any
// valid register write restarts the frame; write only while the block idles.
// Throughput: one pixel at a time. A word that yields no result passes S_LOAD
// only and a border result S_LOAD and S_FIN; an interior result walks the
// window columns through the cell chain in S_COMP, drains the accumulators
// along the chain in S_DRAIN, then passes S_MUL, S_INTERP and S_FIN before
// o_px.valid rises and the next word is taken. The column walk over the window
// cells and the accumulator drain along the chain set the pace of that path.
// The output word sits in a register, so a new pixel is taken while it waits;
// a stalled receiver holds the block only when the next result is ready.
// Reset restores the register defaults and zeroes counters and window; the
// line store is not cleared and needs no clearing pass.
module geometric_mean_window_filter import gmw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gmw_in_if.sink    i_px,
    gmw_out_if.source o_px,
    gmw_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_COMP, S_DRAIN, S_MUL, S_INTERP, S_FIN
    } t_state;

    t_state r_state;

    logic [2:0]            r_half_x, r_half_y;
    logic [10:0]           r_frame_width, r_frame_height;
    logic [CFG_DATA_W-1:0] r_area_recip;

    logic [COL_W-1:0]  r_col, r_ocol;
    logic [ROW_W-1:0]  r_row, r_orow;
    logic [20:0]       r_pos;
    logic [PIX_W-1:0]  r_pix;
    logic [RING_W-1:0] r_bank;
    logic              r_emit, r_inner, r_last;
    logic [SEL_W-1:0]  r_sel, r_drain_cnt;
    t_acc              r_tot;
    logic [CHANNELS-1:0][26:0] r_l;
    logic [CHANNELS-1:0][17:0] r_base;
    logic [CHANNELS-1:0][29:0] r_prod;
    logic [CHANNELS-1:0][2:0]  r_e;
    logic [CHANNELS-1:0]       r_big;

    logic                     r_out_valid, r_out_last;
    logic [CHANNELS-1:0][7:0] r_out;

    // clamped configuration
    logic [2:0]  hx, hy;
    logic [10:0] w, h;
    assign hx = (r_half_x > 3'(MAX_HALF)) ? 3'(MAX_HALF) : r_half_x;
    assign hy = (r_half_y > 3'(MAX_HALF)) ? 3'(MAX_HALF) : r_half_y;
    assign w  = (r_frame_width == 11'd0) ? 11'd1 :
                ((r_frame_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_frame_width);
    assign h  = (r_frame_height == 11'd0) ? 11'd1 :
                ((r_frame_height > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : r_frame_height);

    // words to take before the first result
    logic [20:0] lag;
    assign lag = 21'(hy) * 21'(w) + 21'(hx);

    logic cfg_hit, in_acc, out_load;
    assign cfg_hit = i_cfg.valid && (i_cfg.index <= CFG_IDX_W'(REG_AREA_RECIP));
    assign in_acc  = i_px.valid && i_px.ready;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_px.ready);

    assign i_cfg.ready = 1'b1;
    assign i_px.ready  = (r_state == S_IDLE);

    // incoming word and raster tests on the current counters
    logic [PIX_W-1:0] pix_in;
    logic started, col_wrap, ocol_wrap, inner_now, last_now;
    assign pix_in = i_px.is_pad ? '0 : {i_px.in_blue, i_px.in_green, i_px.in_red};
    assign started   = (r_pos >= lag);
    assign col_wrap  = (11'(r_col) + 11'd1 >= w);
    assign ocol_wrap = (11'(r_ocol) + 11'd1 >= w);
    assign inner_now = (r_orow > ROW_W'(hy)) && (r_ocol > COL_W'(hx)) &&
                       (12'(r_orow) + 12'(hy) < 12'(h)) &&
                       (12'(r_ocol) + 12'(hx) < 12'(w));
    assign last_now  = (12'(r_orow) + 12'd1 == 12'(h)) && ocol_wrap;

    // line store banks
    logic [PIX_W-1:0] bank_q [RING];
    for (genvar g = 0; g < RING; g++) begin : g_bank
        gmw_line_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (in_acc && (r_row[RING_W-1:0] == RING_W'(g))),
            .i_addr  (r_col),
            .i_wdata (pix_in),
            .o_rdata (bank_q[g])
        );
    end

    // cell chain
    t_cell_ctl        ctl;
    t_acc             cell_acc [WIN];
    logic [PIX_W-1:0] feed [WIN];
    assign ctl.clear   = cfg_hit;
    assign ctl.shift   = (r_state == S_LOAD);
    assign ctl.acc_clr = (r_state == S_LOAD);
    assign ctl.acc_add = (r_state == S_COMP);
    assign ctl.drain   = (r_state == S_DRAIN);
    assign ctl.sel     = r_sel;

    for (genvar a = 0; a < WIN; a++) begin : g_cell
        if (a == 0) begin : g_head
            assign feed[a] = r_pix;
            gmw_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
                .i_row_on(1'b1), .i_feed(feed[a]), .i_acc('0), .o_acc(cell_acc[a])
            );
        end else begin : g_body
            assign feed[a] = bank_q[RING_W'(r_bank - RING_W'(a))];
            gmw_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
                .i_row_on(4'(a) <= {hy, 1'b0}), .i_feed(feed[a]),
                .i_acc(cell_acc[a-1]), .o_acc(cell_acc[a])
            );
        end
    end

    // sequencer, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_half_x       <= 3'd1;
            r_half_y       <= 3'd1;
            r_frame_width  <= 11'd640;
            r_frame_height <= 11'd480;
            r_area_recip   <= 17'd7282;
            r_col          <= '0;
            r_row          <= '0;
            r_ocol         <= '0;
            r_orow         <= '0;
            r_pos          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_hit) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_HALF_X:       r_half_x       <= i_cfg.data[2:0];
                    REG_HALF_Y:       r_half_y       <= i_cfg.data[2:0];
                    REG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[10:0];
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[10:0];
                    REG_AREA_RECIP:   r_area_recip   <= i_cfg.data;
                    default: ;
                endcase
                r_col  <= '0;
                r_row  <= '0;
                r_ocol <= '0;
                r_orow <= '0;
                r_pos  <= '0;
            end

            // load a new output word, or drop the old one once taken
            if (out_load)        r_out_valid <= 1'b1;
            else if (o_px.ready) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pix   <= pix_in;
                        r_bank  <= r_row[RING_W-1:0];
                        r_emit  <= started;
                        r_inner <= inner_now;
                        r_last  <= last_now;
                        r_state <= S_LOAD;
                        if (started && last_now) begin
                            r_col  <= '0;
                            r_row  <= '0;
                            r_ocol <= '0;
                            r_orow <= '0;
                            r_pos  <= '0;
                        end else begin
                            r_col <= col_wrap ? '0 : r_col + COL_W'(1);
                            if (col_wrap) r_row <= r_row + ROW_W'(1);
                            r_pos <= r_pos + 21'd1;
                            if (started) begin
                                r_ocol <= ocol_wrap ? '0 : r_ocol + COL_W'(1);
                                if (ocol_wrap) r_orow <= r_orow + ROW_W'(1);
                            end
                        end
                    end
                end
                S_LOAD: begin
                    r_sel <= '0;
                    if (!r_emit)      r_state <= S_IDLE;
                    else if (r_inner) r_state <= S_COMP;
                    else              r_state <= S_FIN;
                end
                S_COMP: begin
                    if (r_sel == {hx, 1'b0}) begin
                        r_drain_cnt <= '0;
                        r_tot       <= '0;
                        r_state     <= S_DRAIN;
                    end else begin
                        r_sel <= r_sel + SEL_W'(1);
                    end
                end
                S_DRAIN: begin
                    for (int k = 0; k < CHANNELS; k++) begin
                        r_tot[k] <= r_tot[k] + cell_acc[WIN-1][k];
                    end
                    r_drain_cnt <= r_drain_cnt + SEL_W'(1);
                    if (r_drain_cnt == SEL_W'(WIN - 1)) r_state <= S_MUL;
                end
                S_MUL: begin
                    for (int k = 0; k < CHANNELS; k++) begin
                        r_l[k] <= 27'((44'(r_tot[k]) * 44'(r_area_recip)) >> 16);
                    end
                    r_state <= S_INTERP;
                end
                S_INTERP: begin
                    for (int k = 0; k < CHANNELS; k++) begin
                        r_base[k] <= EXP_TAB[{1'b0, r_l[k][15:12]}];
                        r_prod[k] <= 30'(EXP_TAB[{1'b0, r_l[k][15:12]} + 5'd1]
                                         - EXP_TAB[{1'b0, r_l[k][15:12]}])
                                     * 30'(r_l[k][11:0]);
                        r_e[k]    <= r_l[k][18:16];
                        r_big[k]  <= |r_l[k][26:19];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // final mantissa scale and saturation
    logic [CHANNELS-1:0][7:0] res;
    always_comb begin
        logic [18:0] m;
        logic [25:0] sh;
        for (int k = 0; k < CHANNELS; k++) begin
            m  = 19'(r_base[k]) + 19'(r_prod[k][29:12]);
            sh = 26'(m) << r_e[k];
            if (!r_inner || r_big[k] || (sh[25:16] > 10'(FILL))) res[k] = FILL;
            else                                                 res[k] = sh[23:16];
        end
    end

    // hold the output word
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out      <= res;
            r_out_last <= r_last;
        end
    end

    assign o_px.valid      = r_out_valid;
    assign o_px.out_red    = r_out[0];
    assign o_px.out_green  = r_out[1];
    assign o_px.out_blue   = r_out[2];
    assign o_px.frame_last = r_out_last;

    // a restart leaves both raster counters at zero
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_col == '0) && (r_row == '0) && (r_ocol == '0) && (r_orow == '0))
        else $error("counters not cleared by configuration write");

    // only interior results walk the cell chain
    a_comp_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_inner && r_emit))
        else $error("window walk on a border or silent word");

    // the column walk never leaves the window
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_sel <= {hx, 1'b0}))
        else $error("column select beyond window");

    // a result is only loaded when the output register is free or drained
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_px.ready && r_state == S_FIN) |=> (r_state == S_FIN))
        else $error("result overwrote a waiting word");

endmodule

@@ tb/gmw_checker.sv @@
// Scoreboard for the geometric mean window filter: watches the pixel, result and
// configuration channels, predicts each result word and compares it field by field.
// Depends on gmw_pkg and gmw_if.
module gmw_checker import gmw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    gmw_in_if    px,
    gmw_out_if   res,
    gmw_cfg_if   cfg,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pix_out;

    // round(2^(i/16) * 65536)
    localparam int unsigned EXP2_POINTS [17] = '{
        65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
        96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072
    };

    t_pix_out          mean_q[$];
    logic [PIX_W-1:0]  line_mem [RING*MAX_WIDTH];
    logic [PIX_W-1:0]  win [WIN][WIN];
    int unsigned       col_pos, row_pos;
    logic [2:0]        half_x, half_y;
    logic [10:0]       frame_w, frame_h;
    logic [16:0]       recip;
    int unsigned       log_lut [256];

    // Q3.16 log2 by repeated squaring, zero treated as one
    function automatic int unsigned sample_log(int unsigned s);
        int unsigned     n;
        int unsigned     acc;
        longint unsigned m;
        if (s == 0) s = 1;
        n = 0;
        while ((s >> (n + 1)) != 0) n++;
        m = longint'(s) << (16 - n);
        acc = n << 16;
        for (int bit_pos = 16; bit_pos > 0; bit_pos--) begin
            m = (m * m) >> 16;
            if (m >= 64'd131072) begin
                m = m >> 1;
                acc = acc | (1 << (bit_pos - 1));
            end
        end
        return acc;
    endfunction

    // scale the log sum by the reciprocal area and go back through exp2
    function automatic logic [7:0] log_sum_to_mean(longint unsigned sum);
        longint unsigned l;
        longint unsigned e;
        int unsigned     f, i, r, m, v;
        l = (sum * longint'(recip)) >> 16;
        e = l >> 16;
        f = 32'(l & 64'hFFFF);
        if (e >= 8) return FILL;
        i = f >> 12;
        r = f & 12'hFFF;
        m = EXP2_POINTS[i] + (((EXP2_POINTS[i+1] - EXP2_POINTS[i]) * r) >> 12);
        v = (m << e) >> 16;
        return (v > 255) ? FILL : v[7:0];
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        for (int a = 0; a < WIN; a++)
            for (int b = 0; b < WIN; b++) win[a][b] = '0;
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_HALF_X:       half_x  = d[2:0];
            REG_HALF_Y:       half_y  = d[2:0];
            REG_FRAME_WIDTH:  frame_w = d[10:0];
            REG_FRAME_HEIGHT: frame_h = d[10:0];
            REG_AREA_RECIP:   recip   = d[16:0];
            default:          return;
        endcase
        restart_frame();
    endfunction

    // advance the window by one word and queue the result it releases, if any
    function automatic void take_pixel(logic [PIX_W-1:0] word);
        int unsigned     hx, hy, w, h, p, d, q, rc, cc;
        bit              inner, last;
        longint unsigned sum;
        logic [7:0]      ch [3];
        t_pix_out        item;
        hx = (half_x > MAX_HALF) ? MAX_HALF : half_x;
        hy = (half_y > MAX_HALF) ? MAX_HALF : half_y;
        w  = (frame_w < 1) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w);
        h  = (frame_h < 1) ? 1 : ((frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = 0;
        end
        for (int a = 0; a < WIN; a++)
            for (int b = WIN - 1; b > 0; b--) win[a][b] = win[a][b-1];
        win[0][0] = word;
        for (int a = 1; a < WIN; a++)
            win[a][0] = line_mem[((row_pos + RING - a) % RING) * MAX_WIDTH + col_pos];
        line_mem[(row_pos % RING) * MAX_WIDTH + col_pos] = word;

        p = row_pos * w + col_pos;
        d = hy * w + hx;
        if (p < d) begin
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            return;
        end
        q  = p - d;
        rc = q / w;
        cc = q % w;
        inner = rc > hy && cc > hx && rc + hy < h && cc + hx < w;
        last  = (q == w * h - 1);
        for (int k = 0; k < 3; k++) begin
            ch[k] = FILL;
            if (inner) begin
                sum = 0;
                for (int a = 0; a <= 2 * hy; a++)
                    for (int b = 0; b <= 2 * hx; b++)
                        sum += log_lut[(win[a][b] >> (8 * k)) & 8'hFF];
                ch[k] = log_sum_to_mean(sum);
            end
        end
        item.red   = ch[0];
        item.green = ch[1];
        item.blue  = ch[2];
        item.last  = last;
        mean_q.push_back(item);
        if (last) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        end
    endfunction

    initial begin
        for (int s = 0; s < 256; s++) log_lut[s] = sample_log(s);
    end

    always @(posedge i_clk) begin
        t_pix_out want;
        int       fails;
        fails = 0;
        if (!i_rst_n) begin
            mean_q.delete();
            half_x  = 3'd1;
            half_y  = 3'd1;
            frame_w = 11'd640;
            frame_h = 11'd480;
            recip   = 17'd7282;
            restart_frame();
            o_errors  <= 0;
            o_checked <= 0;
        end else begin
            // compare first so a word cannot match its own prediction
            if (res.valid && res.ready) begin
                if (mean_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    want = mean_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (res.out_red !== want.red) begin
                        $error("out_red: expected %0d, actual %0d", want.red, res.out_red);
                        fails++;
                    end
                    if (res.out_green !== want.green) begin
                        $error("out_green: expected %0d, actual %0d", want.green,
                               res.out_green);
                        fails++;
                    end
                    if (res.out_blue !== want.blue) begin
                        $error("out_blue: expected %0d, actual %0d", want.blue, res.out_blue);
                        fails++;
                    end
                    if (res.frame_last !== want.last) begin
                        $error("frame_last: expected %0d, actual %0d", want.last,
                               res.frame_last);
                        fails++;
                    end
                end
            end
            o_errors <= o_errors + fails;
            if (cfg.valid && cfg.ready) write_reg(cfg.index, cfg.data);
            if (px.valid && px.ready)
                take_pixel(px.is_pad ? '0 : {px.in_blue, px.in_green, px.in_red});
        end
        o_pending <= mean_q.size();
    end

endmodule

@@ tb/geometric_mean_window_filter_tb.sv @@
// Top of the geometric mean window filter bench: clock, reset, pixel and
// configuration stimulus, receiver stalls and the verdict. Depends on gmw_pkg,
// gmw_if, gmw_checker and the filter itself.
module geometric_mean_window_filter_tb;
    import gmw_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE      = 40;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   words_sent;
    int   settings;
    int   mism;
    int   pending;
    int   checked;
    bit   calm;

    gmw_in_if  px();
    gmw_out_if res();
    gmw_cfg_if cfg();

    geometric_mean_window_filter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (px),
        .o_px    (res),
        .i_cfg   (cfg)
    );

    gmw_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .px        (px),
        .res       (res),
        .cfg       (cfg),
        .o_errors  (mism),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("geometric_mean_window_filter test failed");
            $finish;
        end
    end

    // receiver: stall in bursts, steady in the last part
    initial begin
        forever begin
            if (calm) begin
                res.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                res.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // send one pixel word, with an occasional idle burst ahead of it
    task automatic put_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic pad);
        if (!calm && $urandom_range(0, 7) == 0) begin
            px.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        px.valid    <= 1'b1;
        px.in_red   <= r;
        px.in_green <= g;
        px.in_blue  <= b;
        px.is_pad   <= pad;
        @(posedge i_clk);
        while (!px.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold until every result is in and the back end has drained
    task automatic wait_idle();
        px.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apply a window setting; returns the effective sizes for the frame loop
    task automatic set_window(input int hx, input int hy, input int w, input int h,
                              input int recip, output int hxs, output int hys,
                              output int ws, output int hs);
        wait_idle();
        write_reg(REG_HALF_X, CFG_DATA_W'(hx));
        write_reg(REG_HALF_Y, CFG_DATA_W'(hy));
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_AREA_RECIP, CFG_DATA_W'(recip));
        hxs = (hx > MAX_HALF) ? MAX_HALF : hx;
        hys = (hy > MAX_HALF) ? MAX_HALF : hy;
        ws  = (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        hs  = (h < 1) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
        settings++;
    endtask

    // one frame of random content plus its flush words
    task automatic run_frame(input int hxs, input int hys, input int ws, input int hs);
        for (int i = 0; i < ws * hs; i++)
            put_pixel(pick_sample(), pick_sample(), pick_sample(),
                      $urandom_range(0, 39) == 0);
        for (int i = 0; i < hys * ws + hxs; i++)
            put_pixel(pick_sample(), pick_sample(), pick_sample(),
                      $urandom_range(0, 3) != 0);
    endtask

    // the opening part of a frame only; the next setting restarts it
    task automatic run_partial(input int n);
        for (int i = 0; i < n; i++)
            put_pixel(pick_sample(), pick_sample(), pick_sample(),
                      $urandom_range(0, 39) == 0);
    endtask

    function automatic int area_recip_of(input int hxs, input int hys);
        int area;
        area = (2 * hxs + 1) * (2 * hys + 1);
        return (65536 + area / 2) / area;
    endfunction

    initial begin
        int hx, hy, w, h, hxs, hys, ws, hs, recip;
        logic [7:0] corner [16];
        words_sent = 0;
        settings   = 0;
        calm       = 1'b0;
        i_rst_n    <= 1'b0;
        px.valid   <= 1'b0;
        px.in_red  <= '0;
        px.in_green <= '0;
        px.in_blue <= '0;
        px.is_pad  <= 1'b0;
        cfg.valid  <= 1'b0;
        cfg.index  <= '0;
        cfg.data   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 4x4 frame with 3x3 window, extreme samples, pad inside the
        // frame, real pixels during the flush
        set_window(1, 1, 4, 4, 7282, hxs, hys, ws, hs);
        corner = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd255, 8'd0, 8'd255, 8'd2,
                   8'd254, 8'd255, 8'd0, 8'd127, 8'd255, 8'd3, 8'd64, 8'd255};
        for (int i = 0; i < 16; i++)
            put_pixel(corner[i], ~corner[i], corner[(i + 5) % 16], i == 9);
        put_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        put_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        put_pixel(8'd170, 8'd85, 8'd1, 1'b0);
        put_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        put_pixel(8'd0, 8'd0, 8'd0, 1'b1);

        // unknown register index must leave the setting alone
        wait_idle();
        cfg.valid <= 1'b1;
        cfg.index <= CFG_IDX_W'($urandom_range(5, 7));
        cfg.data  <= CFG_DATA_W'($urandom_range(0, 131071));
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        run_frame(hxs, hys, ws, hs);

        // extreme settings: identity window, saturated exp, degenerate frames
        set_window(0, 0, 3, 3, 65536, hxs, hys, ws, hs);
        run_frame(hxs, hys, ws, hs);
        set_window(1, 0, 5, 3, 131071, hxs, hys, ws, hs);
        run_frame(hxs, hys, ws, hs);
        set_window(7, 7, 0, 0, 0, hxs, hys, ws, hs);
        run_frame(hxs, hys, ws, hs);
        set_window(4, 4, 10, 10, area_recip_of(4, 4), hxs, hys, ws, hs);
        run_frame(hxs, hys, ws, hs);
        set_window(0, 0, 2047, 1, 65536, hxs, hys, ws, hs);
        run_partial(64);
        set_window(0, 3, 1, 2047, 9362, hxs, hys, ws, hs);
        run_partial(64);
        set_window(5, 6, 12, 11, 1928, hxs, hys, ws, hs);
        run_frame(hxs, hys, ws, hs);

        // random settings, mostly small frames
        while (words_sent < 900) begin
            hx = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
            hy = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
            w  = $urandom_range(1, 12);
            h  = $urandom_range(1, 10);
            hxs = (hx > MAX_HALF) ? MAX_HALF : hx;
            hys = (hy > MAX_HALF) ? MAX_HALF : hy;
            recip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                : area_recip_of(hxs, hys);
            if (words_sent > 750) calm = 1'b1;
            set_window(hx, hy, w, h, recip, hxs, hys, ws, hs);
            repeat ($urandom_range(1, 2)) run_frame(hxs, hys, ws, hs);
        end

        px.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d window settings including saturated sizes and degenerate frames;",
                 settings);
        $display("%0d results compared against the log/exp2 mean prediction.", checked);
        if (mism == 0 && pending == 0) begin
            $display("geometric_mean_window_filter test passed");
        end else begin
            $display("geometric_mean_window_filter test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/gmw_pkg.sv
src/gmw_if.sv
src/gmw_line_bank.sv
src/gmw_cell.sv
src/geometric_mean_window_filter.sv
tb/gmw_checker.sv
tb/geometric_mean_window_filter_tb.sv
